>>> hdl/pbrq_pkg.sv
// Package: shared constants and codes for the bitmap priority scheduler.
`default_nettype none
package pbrq_pkg;
  localparam int NUM_THREADS_DEF = 32;
  localparam int NUM_LEVELS_DEF  = 32;

  localparam logic [2:0] OP_READY     = 3'd0;
  localparam logic [2:0] OP_UNREADY   = 3'd1;
  localparam logic [2:0] OP_SELECT    = 3'd2;
  localparam logic [2:0] OP_SET_PRIO  = 3'd3;
  localparam logic [2:0] OP_BLOCK     = 3'd4;
  localparam logic [2:0] OP_YIELD     = 3'd5;
  localparam logic [2:0] OP_READ_PRIO = 3'd6;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_READY = 2'd1;
  localparam logic [1:0] STAT_BAD      = 2'd2;

  localparam logic [2:0] THR_IDLE       = 3'd0;
  localparam logic [2:0] THR_READY      = 3'd1;
  localparam logic [2:0] THR_RUNNING    = 3'd2;
  localparam logic [2:0] THR_WAITING    = 3'd3;
  localparam logic [2:0] THR_TERMINATED = 3'd4;
endpackage
`default_nettype wire

>>> hdl/priority_bitmap_ready_queue_scheduler_unit.sv
// Top level: thread scheduler with per-level FIFO ready queues in link memories.
// S_DEC decodes the beat, a list pass is an S_RD read then an S_EXEC write, and S_FIN
// raises done. Ready and yield put at a tail, unready takes out, set priority on a ready
// thread moves it to the new tail, select heads a preempted runner and takes the top head.
// Throughput: one op at a time; busy drops with the result beat, which shows for one cycle.
// Reset (rst, synchronous): all threads idle at priority 0, no level ready, no current thread.
`default_nettype none
module priority_bitmap_ready_queue_scheduler_unit #(
  parameter int NUM_THREADS = pbrq_pkg::NUM_THREADS_DEF,
  parameter int NUM_LEVELS  = pbrq_pkg::NUM_LEVELS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] op,
  input  wire logic [4:0] thread_id,
  input  wire logic [4:0] priority_req,
  input  wire logic       block_kind,
  output logic            done,
  output logic [4:0]      chosen_thread,
  output logic            chosen_valid,
  output logic [4:0]      priority_out,
  output logic            reschedule,
  output logic [1:0]      status
);
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // list primitives run by one read pass and one write pass (P_FIND writes nothing)
  localparam logic [1:0] P_PUT_TAIL = 2'd0;
  localparam logic [1:0] P_PUT_HEAD = 2'd1;
  localparam logic [1:0] P_TAKE     = 2'd2;
  localparam logic [1:0] P_FIND     = 2'd3;

  logic [2:0]  state;
  logic [1:0]  prim;
  logic [2:0]  op_r;
  logic [4:0]  tid_r;
  logic [LW-1:0] req_r;
  logic        kind_r;
  logic [TW-1:0] t;
  logic [LW-1:0] lv;
  logic [LW-1:0] hi_r;

  logic [NUM_LEVELS-1:0] ready_bitmap;
  logic [LW-1:0] thread_prio [NUM_THREADS];
  logic [2:0]    thread_status [NUM_THREADS];
  logic [TW-1:0] current_thread;
  logic          current_valid;
  logic          cur_run;   // status of current thread is running
  logic [LW-1:0] cur_prio;  // mirror of the current thread's priority

  // link and queue-end memories, read data registered
  logic [TW-1:0] next_link  [NUM_THREADS];
  logic [TW-1:0] prev_link  [NUM_THREADS];
  logic [TW-1:0] level_head [NUM_LEVELS];
  logic [TW-1:0] level_tail [NUM_LEVELS];
  logic [TW-1:0] rd_nxt, rd_prv, rd_head, rd_tail;

  logic          nxt_we, prv_we, head_we, tail_we;
  logic [TW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, head_wd, tail_wd;

  // highest non-empty level
  logic [LW-1:0] hi_lv;
  logic          hi_any;
  always_comb begin
    hi_lv  = '0;
    hi_any = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ready_bitmap[i]) begin
        hi_lv  = LW'(i);
        hi_any = 1'b1;
      end
    end
  end

  logic          running;
  logic          tid_ok;
  logic [TW-1:0] tidx;
  logic [2:0]    st_t;
  logic [LW-1:0] pr_t;
  logic          lv_busy;
  logic          is_head, is_tail;
  assign running = current_valid & cur_run;
  assign tid_ok  = 32'(tid_r) < NUM_THREADS;
  assign tidx    = TW'(tid_r);
  assign st_t    = thread_status[tidx];
  assign pr_t    = thread_prio[tidx];
  assign lv_busy = ready_bitmap[lv];
  assign is_head = rd_head == t;
  assign is_tail = rd_tail == t;
  assign busy    = state != S_IDLE;

  // write ports of the link memories, all driven in the write pass
  always_comb begin
    nxt_we = 1'b0; nxt_wa = t; nxt_wd = t;
    prv_we = 1'b0; prv_wa = t; prv_wd = t;
    head_we = 1'b0; head_wd = t;
    tail_we = 1'b0; tail_wd = t;
    if (state == S_EXEC) begin
      case (prim)
        P_PUT_TAIL: begin
          if (lv_busy) begin
            prv_we = 1'b1; prv_wa = t; prv_wd = rd_tail;
            nxt_we = 1'b1; nxt_wa = rd_tail; nxt_wd = t;
            tail_we = 1'b1;
          end else begin
            head_we = 1'b1;
            tail_we = 1'b1;
          end
        end
        P_PUT_HEAD: begin
          if (lv_busy) begin
            nxt_we = 1'b1; nxt_wa = t; nxt_wd = rd_head;
            prv_we = 1'b1; prv_wa = rd_head; prv_wd = t;
            head_we = 1'b1;
          end else begin
            head_we = 1'b1;
            tail_we = 1'b1;
          end
        end
        P_TAKE: begin
          if (is_head && is_tail) begin
            // level empties, bitmap clears below
          end else if (is_head) begin
            head_we = 1'b1; head_wd = rd_nxt;
          end else if (is_tail) begin
            tail_we = 1'b1; tail_wd = rd_prv;
          end else begin
            nxt_we = 1'b1; nxt_wa = rd_prv; nxt_wd = rd_nxt;
            prv_we = 1'b1; prv_wa = rd_nxt; prv_wd = rd_prv;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_nxt  <= next_link[t];
    rd_prv  <= prev_link[t];
    rd_head <= level_head[lv];
    rd_tail <= level_tail[lv];
    if (nxt_we) next_link[nxt_wa] <= nxt_wd;
    if (prv_we) prev_link[prv_wa] <= prv_wd;
    if (head_we) level_head[lv] <= head_wd;
    if (tail_we) level_tail[lv] <= tail_wd;
  end

  // sequencer, thread table and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      ready_bitmap   <= '0;
      current_thread <= '0;
      current_valid  <= 1'b0;
      cur_run        <= 1'b0;
      cur_prio       <= '0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        thread_prio[i]   <= '0;
        thread_status[i] <= pbrq_pkg::THR_IDLE;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            // latch the beat and clear the result fields other than reschedule
            op_r   <= op;
            tid_r  <= thread_id;
            kind_r <= block_kind;
            req_r  <= (32'(priority_req) > NUM_LEVELS - 1) ? LW'(NUM_LEVELS - 1)
                                                           : LW'(priority_req);
            chosen_thread <= '0;
            chosen_valid  <= 1'b0;
            priority_out  <= '0;
            status        <= pbrq_pkg::STAT_OK;
            state         <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_FIN;
          case (op_r)
            pbrq_pkg::OP_READY: begin
              if (!tid_ok || st_t == pbrq_pkg::THR_READY ||
                  st_t == pbrq_pkg::THR_TERMINATED) begin
                status <= pbrq_pkg::STAT_BAD;
              end else begin
                t <= tidx; lv <= pr_t; prim <= P_PUT_TAIL; state <= S_RD;
              end
            end
            pbrq_pkg::OP_UNREADY: begin
              if (!tid_ok || st_t != pbrq_pkg::THR_READY) begin
                status <= pbrq_pkg::STAT_BAD;
              end else begin
                t <= tidx; lv <= pr_t; prim <= P_TAKE; state <= S_RD;
              end
            end
            pbrq_pkg::OP_SELECT: begin
              if (running) begin
                if (hi_any && hi_lv > cur_prio) begin
                  // preempt: current goes back to the head of its level
                  t <= current_thread; lv <= cur_prio; hi_r <= hi_lv;
                  prim <= P_PUT_HEAD; state <= S_RD;
                end else begin
                  chosen_thread <= 5'(current_thread);
                  chosen_valid  <= 1'b1;
                end
              end else if (!hi_any) begin
                status <= pbrq_pkg::STAT_NO_READY;
              end else begin
                lv <= hi_lv; prim <= P_FIND; state <= S_RD;
              end
            end
            pbrq_pkg::OP_SET_PRIO: begin
              if (!tid_ok) begin
                status <= pbrq_pkg::STAT_BAD;
              end else if (pr_t != req_r) begin
                if (st_t == pbrq_pkg::THR_READY) begin
                  t <= tidx; lv <= pr_t; prim <= P_TAKE; state <= S_RD;
                end else begin
                  thread_prio[tidx] <= req_r;
                  if (tidx == current_thread) cur_prio <= req_r;
                end
              end
            end
            pbrq_pkg::OP_BLOCK: begin
              if (!running) begin
                status <= pbrq_pkg::STAT_BAD;
              end else begin
                thread_status[current_thread] <= kind_r ? pbrq_pkg::THR_TERMINATED
                                                        : pbrq_pkg::THR_WAITING;
                cur_run <= 1'b0;
              end
            end
            pbrq_pkg::OP_YIELD: begin
              if (!running) begin
                status <= pbrq_pkg::STAT_BAD;
              end else if (ready_bitmap[cur_prio]) begin
                t <= current_thread; lv <= cur_prio; prim <= P_PUT_TAIL; state <= S_RD;
              end
            end
            pbrq_pkg::OP_READ_PRIO: begin
              if (!tid_ok) begin
                status <= pbrq_pkg::STAT_BAD;
              end else begin
                chosen_thread <= tid_r;
                chosen_valid  <= 1'b1;
                priority_out  <= 5'(pr_t);
              end
            end
            default: begin
              status <= pbrq_pkg::STAT_BAD;
            end
          endcase
        end
        S_RD: begin
          // read data for (t, lv) lands in the rd_* registers
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FIN;
          case (prim)
            P_PUT_TAIL, P_PUT_HEAD: begin
              if (!lv_busy) ready_bitmap[lv] <= 1'b1;
              thread_status[t] <= pbrq_pkg::THR_READY;
              if (t == current_thread) cur_run <= 1'b0;
              if (op_r == pbrq_pkg::OP_SELECT) begin
                lv <= hi_r; prim <= P_FIND; state <= S_RD;
              end
            end
            P_FIND: begin
              t <= rd_head; prim <= P_TAKE; state <= S_RD;
            end
            default: begin
              if (is_head && is_tail) ready_bitmap[lv] <= 1'b0;
              if (op_r == pbrq_pkg::OP_SELECT) begin
                // head of the top level becomes the running thread
                thread_status[t] <= pbrq_pkg::THR_RUNNING;
                current_thread   <= t;
                current_valid    <= 1'b1;
                cur_run          <= 1'b1;
                cur_prio         <= lv;
                chosen_thread    <= 5'(t);
                chosen_valid     <= 1'b1;
              end else if (op_r == pbrq_pkg::OP_SET_PRIO) begin
                // requeue at the tail of the new level
                thread_status[t] <= pbrq_pkg::THR_IDLE;
                thread_prio[t]   <= req_r;
                if (t == current_thread) begin
                  cur_prio <= req_r;
                  cur_run  <= 1'b0;
                end
                lv <= req_r; prim <= P_PUT_TAIL; state <= S_RD;
              end else begin
                thread_status[t] <= pbrq_pkg::THR_IDLE;
                if (t == current_thread) cur_run <= 1'b0;
              end
            end
          endcase
        end
        S_FIN: begin
          // reschedule reflects the state after the op
          reschedule <= !running || (hi_any && hi_lv > cur_prio);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

>>> dv/tb_priority_bitmap_ready_queue_scheduler_unit.sv
// Testbench for the bitmap priority scheduler: directed and random ops checked against a predictor.
`default_nettype none
module tb_priority_bitmap_ready_queue_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTHR = 32;
  localparam int NLVL = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_OPS = 1600;

  typedef struct {
    logic [2:0] op;
    logic [4:0] tid;
    logic [4:0] prio_req;
    logic       kind;
    bit         drain;  // hold this beat until every result is back
  } sched_cmd_t;

  typedef struct {
    logic [4:0] chosen_thread;
    logic       chosen_valid;
    logic [4:0] priority_out;
    logic       reschedule;
    logic [1:0] status;
  } sched_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] op = pbrq_pkg::OP_READY;
  logic [4:0] thread_id = '0;
  logic [4:0] priority_req = '0;
  logic       block_kind = 1'b0;
  wire        busy, done, chosen_valid, reschedule;
  wire  [4:0] chosen_thread, priority_out;
  wire  [1:0] status;

  priority_bitmap_ready_queue_scheduler_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .thread_id(thread_id), .priority_req(priority_req), .block_kind(block_kind),
    .done(done), .chosen_thread(chosen_thread), .chosen_valid(chosen_valid),
    .priority_out(priority_out), .reschedule(reschedule), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the scheduler's thread table and ready queues.
  logic [4:0]  nxt_lnk [NTHR];
  logic [4:0]  prv_lnk [NTHR];
  logic [4:0]  lvl_head [NLVL];
  logic [4:0]  lvl_tail [NLVL];
  logic [31:0] ready_levels;
  logic [4:0]  thr_prio [NTHR];
  logic [2:0]  thr_state [NTHR];
  logic [4:0]  cur_thr;
  logic        cur_ok;

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_results[$];
  sched_cmd_t drv_cmd;
  int         beats_sent, results_checked, errors, idle_cycles;
  int         status_seen [4];
  int         burst_left, gap_left;

  function automatic int top_level();
    for (int lv = NLVL - 1; lv >= 0; lv--)
      if (ready_levels[lv]) return lv;
    return -1;
  endfunction

  function automatic bit cur_running();
    return cur_ok && thr_state[cur_thr] == pbrq_pkg::THR_RUNNING;
  endfunction

  function automatic void enqueue_tail(logic [4:0] t);
    logic [4:0] lv;
    lv = thr_prio[t];
    if (ready_levels[lv]) begin
      prv_lnk[t] = lvl_tail[lv];
      nxt_lnk[lvl_tail[lv]] = t;
      lvl_tail[lv] = t;
    end else begin
      lvl_head[lv] = t;
      lvl_tail[lv] = t;
      ready_levels[lv] = 1'b1;
    end
    thr_state[t] = pbrq_pkg::THR_READY;
  endfunction

  function automatic void enqueue_head(logic [4:0] t);
    logic [4:0] lv;
    lv = thr_prio[t];
    if (ready_levels[lv]) begin
      nxt_lnk[t] = lvl_head[lv];
      prv_lnk[lvl_head[lv]] = t;
      lvl_head[lv] = t;
    end else begin
      lvl_head[lv] = t;
      lvl_tail[lv] = t;
      ready_levels[lv] = 1'b1;
    end
    thr_state[t] = pbrq_pkg::THR_READY;
  endfunction

  function automatic void unlink(logic [4:0] t);
    logic [4:0] lv;
    bit at_head, at_tail;
    lv = thr_prio[t];
    at_head = lvl_head[lv] == t;
    at_tail = lvl_tail[lv] == t;
    if (at_head && at_tail) ready_levels[lv] = 1'b0;
    else if (at_head) lvl_head[lv] = nxt_lnk[t];
    else if (at_tail) lvl_tail[lv] = prv_lnk[t];
    else begin
      nxt_lnk[prv_lnk[t]] = nxt_lnk[t];
      prv_lnk[nxt_lnk[t]] = prv_lnk[t];
    end
    thr_state[t] = pbrq_pkg::THR_IDLE;
  endfunction

  // Apply one op to the mirror and return the result beat it should produce.
  function automatic sched_res_t schedule_op(sched_cmd_t c);
    sched_res_t r;
    int hi;
    r = '{chosen_thread: '0, chosen_valid: 1'b0, priority_out: '0,
          reschedule: 1'b0, status: pbrq_pkg::STAT_OK};
    case (c.op)
      pbrq_pkg::OP_READY: begin
        if (thr_state[c.tid] inside {pbrq_pkg::THR_IDLE, pbrq_pkg::THR_RUNNING,
                                     pbrq_pkg::THR_WAITING}) enqueue_tail(c.tid);
        else r.status = pbrq_pkg::STAT_BAD;
      end
      pbrq_pkg::OP_UNREADY: begin
        if (thr_state[c.tid] != pbrq_pkg::THR_READY) r.status = pbrq_pkg::STAT_BAD;
        else unlink(c.tid);
      end
      pbrq_pkg::OP_SELECT: begin
        hi = top_level();
        if (cur_running() && !(hi >= 0 && hi > thr_prio[cur_thr])) begin
          r.chosen_thread = cur_thr;
          r.chosen_valid = 1'b1;
        end else if (!cur_running() && hi < 0) begin
          r.status = pbrq_pkg::STAT_NO_READY;
        end else begin
          // preempted runner goes back to the front of its level
          if (cur_running()) enqueue_head(cur_thr);
          cur_thr = lvl_head[hi];
          cur_ok = 1'b1;
          unlink(cur_thr);
          thr_state[cur_thr] = pbrq_pkg::THR_RUNNING;
          r.chosen_thread = cur_thr;
          r.chosen_valid = 1'b1;
        end
      end
      pbrq_pkg::OP_SET_PRIO: begin
        if (thr_prio[c.tid] != c.prio_req) begin
          if (thr_state[c.tid] == pbrq_pkg::THR_READY) begin
            unlink(c.tid);
            thr_prio[c.tid] = c.prio_req;
            enqueue_tail(c.tid);
          end else thr_prio[c.tid] = c.prio_req;
        end
      end
      pbrq_pkg::OP_BLOCK: begin
        if (!cur_running()) r.status = pbrq_pkg::STAT_BAD;
        else thr_state[cur_thr] = c.kind ? pbrq_pkg::THR_TERMINATED : pbrq_pkg::THR_WAITING;
      end
      pbrq_pkg::OP_YIELD: begin
        if (!cur_running()) r.status = pbrq_pkg::STAT_BAD;
        else if (ready_levels[thr_prio[cur_thr]]) enqueue_tail(cur_thr);
      end
      pbrq_pkg::OP_READ_PRIO: begin
        r.chosen_thread = c.tid;
        r.chosen_valid = 1'b1;
        r.priority_out = thr_prio[c.tid];
      end
      default: r.status = pbrq_pkg::STAT_BAD;
    endcase
    hi = top_level();
    r.reschedule = !cur_running() || (hi >= 0 && hi > thr_prio[cur_thr]);
    return r;
  endfunction

  function automatic sched_cmd_t mk_cmd(logic [2:0] o, logic [4:0] t, logic [4:0] p,
                                        logic k);
    sched_cmd_t c;
    c = '{op: o, tid: t, prio_req: p, kind: k, drain: 1'b0};
    return c;
  endfunction

  // Weighted random op: enough readies and selects to keep the queues populated,
  // few priority values so levels collide, terminations kept rare.
  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int w;
    logic [2:0] o;
    w = $urandom_range(0, 99);
    if (w < 28) o = pbrq_pkg::OP_READY;
    else if (w < 36) o = pbrq_pkg::OP_UNREADY;
    else if (w < 56) o = pbrq_pkg::OP_SELECT;
    else if (w < 66) o = pbrq_pkg::OP_SET_PRIO;
    else if (w < 76) o = pbrq_pkg::OP_BLOCK;
    else if (w < 86) o = pbrq_pkg::OP_YIELD;
    else if (w < 97) o = pbrq_pkg::OP_READ_PRIO;
    else o = 3'd7;
    c = mk_cmd(o, 5'($urandom_range(0, 31)),
               $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31)),
               $urandom_range(0, 15) == 0);
    return c;
  endfunction

  initial begin
    sched_cmd_t c;
    ready_levels = '0;
    cur_thr = '0;
    cur_ok = 1'b0;
    for (int i = 0; i < NTHR; i++) begin
      thr_prio[i] = '0;
      thr_state[i] = pbrq_pkg::THR_IDLE;
      nxt_lnk[i] = '0;
      prv_lnk[i] = '0;
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
    end
    // directed: empty select, field extremes, every op, wrong-state yield, block, unready and ready
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SELECT, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_YIELD, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_BLOCK, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_UNREADY, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READ_PRIO, 5'd31, 5'd31, 1'b1));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SET_PRIO, 5'd31, 5'd31, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SET_PRIO, 5'd31, 5'd31, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd31, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd31, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SELECT, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_YIELD, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd1, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SET_PRIO, 5'd1, 5'd31, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SELECT, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_YIELD, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SELECT, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SET_PRIO, 5'd0, 5'd30, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_BLOCK, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd1, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_SELECT, 5'd0, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_BLOCK, 5'd0, 5'd0, 1'b1));
    pending_cmds.push_back(mk_cmd(pbrq_pkg::OP_READY, 5'd1, 5'd0, 1'b0));
    pending_cmds.push_back(mk_cmd(3'd7, 5'd0, 5'd0, 1'b0));
    for (int i = 0; i < RANDOM_OPS; i++) begin
      c = rand_cmd();
      c.drain = (i % 400) == 200;
      pending_cmds.push_back(c);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d ops, checked %0d result beats (ok %0d, no-ready %0d, bad %0d).",
             beats_sent, results_checked, status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0 && expected_results.size() == 0)
      $display("priority_bitmap_ready_queue_scheduler_unit: match");
    else
      $display("priority_bitmap_ready_queue_scheduler_unit: mismatch");
    $finish;
  end

  // Driver: predict on each accepted beat, then present the next command in bursts.
  always @(posedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(schedule_op(drv_cmd));
        beats_sent++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain || expected_results.size() == 0)) begin
          drv_cmd = pending_cmds.pop_front();
          op <= drv_cmd.op;
          thread_id <= drv_cmd.tid;
          priority_req <= drv_cmd.prio_req;
          block_kind <= drv_cmd.kind;
          nxt_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
    start <= nxt_start;
  end

  // Monitor: each done beat is checked against the oldest prediction.
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
      end else begin
        e = expected_results.pop_front();
        results_checked++;
        status_seen[e.status]++;
        if (chosen_thread !== e.chosen_thread) begin
          $error("chosen_thread exp %0d got %0d", e.chosen_thread, chosen_thread);
          errors++;
        end
        if (chosen_valid !== e.chosen_valid) begin
          $error("chosen_valid exp %0d got %0d", e.chosen_valid, chosen_valid);
          errors++;
        end
        if (priority_out !== e.priority_out) begin
          $error("priority_out exp %0d got %0d", e.priority_out, priority_out);
          errors++;
        end
        if (reschedule !== e.reschedule) begin
          $error("reschedule exp %0d got %0d", e.reschedule, reschedule);
          errors++;
        end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status);
          errors++;
        end
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("priority_bitmap_ready_queue_scheduler_unit: mismatch");
      $finish;
    end
  end
endmodule
`default_nettype wire
